@@ rtl/llcm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcm_pkg
// Widths, beat types and the divider step shared by the midpoint pipeline.
// ----------------------------------------------------------------------------
package llcm_pkg;

    localparam int POS_W   = 32;   // Q15.16 positions
    localparam int DIR_W   = 16;   // Q1.15 directions
    localparam int W_W     = 33;   // q1 - q2
    localparam int B_W     = 33;   // b = v1.v2, Q.30
    localparam int DP_W    = 49;   // one w*v product
    localparam int DE_W    = 51;   // d and e, Q.31
    localparam int DEN_W   = 66;   // denom and b*b, Q.60
    localparam int LO_W    = 26;   // low slice of d/e for the b*d, b*e split
    localparam int NUM_W   = 86;   // numerators, Q.61
    localparam int MD_W    = 64;   // |denom|
    localparam int DVD_W   = 100;  // dividend and quotient
    localparam int S_W     = DVD_W + 1;
    localparam int SL_W    = 26;   // slice of s for v*s
    localparam int PP_W    = DIR_W + SL_W + 1;
    localparam int N_W     = 118;  // closest points, Q.31
    localparam int SUM_W   = N_W + 1;
    localparam int MAG_W   = 56;   // clamped |n1-n2|
    localparam int HALF_W  = MAG_W / 2;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int GS_W    = SQ_W + 2;
    localparam int GAP_W   = 48;
    localparam int GAP_SH  = 46;

    localparam int FRONT_STAGES = 6;
    localparam int DIV_STEPS    = DVD_W;
    localparam int BACK_STAGES  = 9;
    localparam int LATENCY      = FRONT_STAGES + DIV_STEPS + BACK_STAGES;

    typedef logic signed [POS_W-1:0] t_pos;
    typedef logic signed [DIR_W-1:0] t_dir;

    typedef struct packed {
        t_pos [2:0] q1;
        t_dir [2:0] v1;
        t_pos [2:0] q2;
        t_dir [2:0] v2;
    } t_geom;

    typedef struct packed {
        logic             neg;
        logic [MD_W-1:0]  md;
        logic [MD_W-1:0]  rem;
        logic [DVD_W-1:0] dvd;
    } t_lane;

    typedef struct packed {
        logic         parallel;
        t_geom        g;
        t_lane [1:0]  lane;
    } t_dbeat;

    // One restoring step: shift in the next dividend bit, subtract when it fits.
    function automatic t_lane div_step(input t_lane l);
        t_lane      r;
        logic [MD_W:0] tr;
        logic [MD_W:0] df;
        r  = l;
        tr = {l.rem, l.dvd[DVD_W-1]};
        df = tr - {1'b0, l.md};
        if (!df[MD_W]) begin
            r.rem = df[MD_W-1:0];
            r.dvd = {l.dvd[DVD_W-2:0], 1'b1};
        end else begin
            r.rem = tr[MD_W-1:0];
            r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

@@ rtl/llcm_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcm_front
// Dot products, denominator and numerators; forms the dividend beats.
// ----------------------------------------------------------------------------
module llcm_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  llcm_pkg::t_geom i_geom,
    output logic            o_vld,
    output llcm_pkg::t_dbeat o_beat
);
    import llcm_pkg::*;

    logic [FRONT_STAGES-2:0] r_vld;

    // stage A
    t_geom                    r_ga;
    logic signed [W_W-1:0]    r_w [3];
    logic signed [2*DIR_W-1:0] r_pb [3];
    // stage B
    t_geom                    r_gb;
    logic signed [B_W-1:0]    r_bb;
    logic signed [DP_W-1:0]   r_pd [3];
    logic signed [DP_W-1:0]   r_pe [3];
    // stage C
    t_geom                    r_gc;
    logic signed [B_W-1:0]    r_bc;
    logic signed [DE_W-1:0]   r_d, r_e;
    logic signed [DEN_W-1:0]  r_bsq;
    // stage D
    t_geom                    r_gd;
    logic                     r_par_d;
    logic signed [DEN_W-1:0]  r_den_d;
    logic signed [DE_W-1:0]   r_d_d, r_e_d;
    logic signed [B_W+LO_W:0]       r_pbe_lo, r_pbd_lo;
    logic signed [B_W+DE_W-LO_W-1:0] r_pbe_hi, r_pbd_hi;
    // stage E
    t_geom                    r_ge;
    logic                     r_par_e;
    logic signed [DEN_W-1:0]  r_den_e;
    logic signed [NUM_W-1:0]  r_num [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else begin
            r_vld <= {r_vld[FRONT_STAGES-3:0], i_vld};
            o_vld <= r_vld[FRONT_STAGES-2];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_w[i]  <= W_W'($signed(i_geom.q1[i])) - W_W'($signed(i_geom.q2[i]));
            r_pb[i] <= $signed(i_geom.v1[i]) * $signed(i_geom.v2[i]);
        end
        r_ga <= i_geom;
    end

    always_ff @(posedge i_clk) begin
        r_bb <= B_W'(r_pb[0]) + B_W'(r_pb[1]) + B_W'(r_pb[2]);
        for (int i = 0; i < 3; i++) begin
            r_pd[i] <= r_w[i] * $signed(r_ga.v1[i]);
            r_pe[i] <= r_w[i] * $signed(r_ga.v2[i]);
        end
        r_gb <= r_ga;
    end

    always_ff @(posedge i_clk) begin
        r_d   <= DE_W'(r_pd[0]) + DE_W'(r_pd[1]) + DE_W'(r_pd[2]);
        r_e   <= DE_W'(r_pe[0]) + DE_W'(r_pe[1]) + DE_W'(r_pe[2]);
        r_bsq <= DEN_W'(r_bb) * DEN_W'(r_bb);
        r_bc  <= r_bb;
        r_gc  <= r_gb;
    end

    // split d and e so each product stays near 32 x 32
    always_ff @(posedge i_clk) begin
        r_den_d  <= (DEN_W'(1) <<< 60) - r_bsq;
        r_par_d  <= (r_bsq == (DEN_W'(1) <<< 60));
        r_pbe_lo <= r_bc * $signed({1'b0, r_e[LO_W-1:0]});
        r_pbd_lo <= r_bc * $signed({1'b0, r_d[LO_W-1:0]});
        r_pbe_hi <= r_bc * $signed(r_e[DE_W-1:LO_W]);
        r_pbd_hi <= r_bc * $signed(r_d[DE_W-1:LO_W]);
        r_d_d    <= r_d;
        r_e_d    <= r_e;
        r_gd     <= r_gc;
    end

    always_ff @(posedge i_clk) begin
        r_num[0] <= (NUM_W'(r_pbe_hi) <<< LO_W) + NUM_W'(r_pbe_lo)
                    - (NUM_W'(r_d_d) <<< 30);
        r_num[1] <= (NUM_W'(r_e_d) <<< 30)
                    - ((NUM_W'(r_pbd_hi) <<< LO_W) + NUM_W'(r_pbd_lo));
        r_den_e  <= r_den_d;
        r_par_e  <= r_par_d;
        r_ge     <= r_gd;
    end

    // magnitudes, sign and rounding offset for the divider
    always_ff @(posedge i_clk) begin
        logic [DEN_W-1:0] mden;
        logic [NUM_W-1:0] mnum;
        mden = r_den_e[DEN_W-1] ? DEN_W'(-r_den_e) : DEN_W'(r_den_e);
        for (int l = 0; l < 2; l++) begin
            mnum = r_num[l][NUM_W-1] ? NUM_W'(-r_num[l]) : NUM_W'(r_num[l]);
            o_beat.lane[l].neg <= r_num[l][NUM_W-1] ^ r_den_e[DEN_W-1];
            o_beat.lane[l].md  <= mden[MD_W-1:0];
            o_beat.lane[l].rem <= '0;
            o_beat.lane[l].dvd <= (DVD_W'(mnum) << 15) + DVD_W'(mden[MD_W-1:1]);
        end
        o_beat.parallel <= r_par_e;
        o_beat.g        <= r_ge;
    end

endmodule

@@ rtl/llcm_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcm_div
// Pipelined restoring divider, one quotient bit per stage, two lanes (s, t).
// ----------------------------------------------------------------------------
module llcm_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  llcm_pkg::t_dbeat i_beat,
    output logic             o_vld,
    output llcm_pkg::t_dbeat o_beat
);
    import llcm_pkg::*;

    logic   r_vld [DIV_STEPS];
    t_dbeat r_dat [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= i_vld;
                end
            end
            always_ff @(posedge i_clk) begin
                t_dbeat n_dat;
                n_dat         = i_beat;
                n_dat.lane[0] = div_step(i_beat.lane[0]);
                n_dat.lane[1] = div_step(i_beat.lane[1]);
                r_dat[k]     <= n_dat;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                t_dbeat n_dat;
                n_dat         = r_dat[k-1];
                n_dat.lane[0] = div_step(r_dat[k-1].lane[0]);
                n_dat.lane[1] = div_step(r_dat[k-1].lane[1]);
                r_dat[k]     <= n_dat;
            end
        end
    end

    assign o_vld  = r_vld[DIV_STEPS-1];
    assign o_beat = r_dat[DIV_STEPS-1];

endmodule

@@ rtl/llcm_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcm_back
// Closest points, midpoint rounding and saturation, squared gap.
// ----------------------------------------------------------------------------
module llcm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  llcm_pkg::t_dbeat         i_beat,
    output logic                     o_vld,
    output logic signed [31:0]       o_mid_x,
    output logic signed [31:0]       o_mid_y,
    output logic signed [31:0]       o_mid_z,
    output logic [47:0]              o_gap_squared,
    output logic                     o_parallel
);
    import llcm_pkg::*;

    logic [BACK_STAGES-2:0] r_vld;
    logic [BACK_STAGES-2:0] r_par;

    // G
    t_geom                   r_gg;
    logic signed [S_W-1:0]   r_s [2];
    // H
    t_geom                   r_gh;
    logic signed [PP_W-1:0]  r_pp [2][3][4];
    // I
    t_geom                   r_gi;
    logic signed [N_W-1:0]   r_vs [2][3];
    // J
    logic signed [N_W-1:0]   r_n [2][3];
    // K
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [SUM_W-1:0] r_df [3];
    // L
    logic signed [POS_W-1:0] r_mid_l [3];
    logic [MAG_W-1:0]        r_mag [3];
    // M
    logic signed [POS_W-1:0] r_mid_m [3];
    logic [MAG_W-1:0]        r_hh [3], r_hl [3], r_ll [3];
    // N
    logic signed [POS_W-1:0] r_mid_n [3];
    logic [SQ_W-1:0]         r_sq [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            o_vld <= 1'b0;
        end else begin
            r_vld <= {r_vld[BACK_STAGES-3:0], i_vld};
            o_vld <= r_vld[BACK_STAGES-2];
        end
    end

    always_ff @(posedge i_clk) begin
        r_par <= {r_par[BACK_STAGES-3:0], i_beat.parallel};
    end

    // G: apply the sign to the quotient
    always_ff @(posedge i_clk) begin
        logic signed [S_W-1:0] sv;
        for (int l = 0; l < 2; l++) begin
            sv = $signed({1'b0, i_beat.lane[l].dvd});
            r_s[l] <= i_beat.lane[l].neg ? -sv : sv;
        end
        r_gg <= i_beat.g;
    end

    // H: v * s in four slices of s
    always_ff @(posedge i_clk) begin
        t_dir v;
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < 3; i++) begin
                v = (l == 0) ? r_gg.v1[i] : r_gg.v2[i];
                r_pp[l][i][0] <= $signed(v) * $signed({1'b0, r_s[l][SL_W-1:0]});
                r_pp[l][i][1] <= $signed(v) * $signed({1'b0, r_s[l][2*SL_W-1:SL_W]});
                r_pp[l][i][2] <= $signed(v) * $signed({1'b0, r_s[l][3*SL_W-1:2*SL_W]});
                r_pp[l][i][3] <= PP_W'($signed(v) * $signed(r_s[l][S_W-1:3*SL_W]));
            end
        end
        r_gh <= r_gg;
    end

    // I: combine the slices
    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            for (int i = 0; i < 3; i++) begin
                r_vs[l][i] <= (N_W'(r_pp[l][i][3]) <<< (3*SL_W))
                            + (N_W'(r_pp[l][i][2]) <<< (2*SL_W))
                            + (N_W'(r_pp[l][i][1]) <<< SL_W)
                            + N_W'(r_pp[l][i][0]);
            end
        end
        r_gi <= r_gh;
    end

    // J: n = q*2^15 + v*s
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_n[0][i] <= (N_W'($signed(r_gi.q1[i])) <<< 15) + r_vs[0][i];
            r_n[1][i] <= (N_W'($signed(r_gi.q2[i])) <<< 15) + r_vs[1][i];
        end
    end

    // K: sum with rounding offset, difference
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sum[i] <= SUM_W'(r_n[0][i]) + SUM_W'(r_n[1][i]) + SUM_W'(32768);
            r_df[i]  <= SUM_W'(r_n[0][i]) - SUM_W'(r_n[1][i]);
        end
    end

    // L: saturate the midpoint, clamp the gap component
    always_ff @(posedge i_clk) begin
        logic signed [SUM_W-17:0] sh;
        logic [SUM_W-1:0]         mg;
        for (int i = 0; i < 3; i++) begin
            sh = r_sum[i][SUM_W-1:16];
            if (sh > (SUM_W-16)'(32'sh7FFF_FFFF)) begin
                r_mid_l[i] <= 32'sh7FFF_FFFF;
            end else if (sh < -(SUM_W-16)'(33'sh0_8000_0000)) begin
                r_mid_l[i] <= 32'sh8000_0000;
            end else begin
                r_mid_l[i] <= sh[POS_W-1:0];
            end
            mg = r_df[i][SUM_W-1] ? SUM_W'(-r_df[i]) : SUM_W'(r_df[i]);
            if (mg > (SUM_W'(1) << (MAG_W-1))) begin
                r_mag[i] <= MAG_W'(1) << (MAG_W-1);
            end else begin
                r_mag[i] <= mg[MAG_W-1:0];
            end
        end
    end

    // M: square partial products
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_hh[i] <= r_mag[i][MAG_W-1:HALF_W] * r_mag[i][MAG_W-1:HALF_W];
            r_hl[i] <= r_mag[i][MAG_W-1:HALF_W] * r_mag[i][HALF_W-1:0];
            r_ll[i] <= r_mag[i][HALF_W-1:0] * r_mag[i][HALF_W-1:0];
            r_mid_m[i] <= r_mid_l[i];
        end
    end

    // N: assemble the squares
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_sq[i] <= (SQ_W'(r_hh[i]) << MAG_W) + (SQ_W'(r_hl[i]) << (HALF_W+1))
                     + SQ_W'(r_ll[i]);
            r_mid_n[i] <= r_mid_m[i];
        end
    end

    // O: sum, round, saturate; zero the midpoint and gap for parallel lines
    always_ff @(posedge i_clk) begin
        logic [GS_W-1:0] gs;
        gs = GS_W'(r_sq[0]) + GS_W'(r_sq[1]) + GS_W'(r_sq[2])
           + (GS_W'(1) << (GAP_SH-1));
        if (r_par[BACK_STAGES-2]) begin
            o_mid_x       <= '0;
            o_mid_y       <= '0;
            o_mid_z       <= '0;
            o_gap_squared <= '0;
        end else begin
            o_mid_x <= r_mid_n[0];
            o_mid_y <= r_mid_n[1];
            o_mid_z <= r_mid_n[2];
            if (|gs[GS_W-1:GAP_SH+GAP_W]) begin
                o_gap_squared <= '1;
            end else begin
                o_gap_squared <= gs[GAP_SH+GAP_W-1:GAP_SH];
            end
        end
        o_parallel <= r_par[BACK_STAGES-2];
    end

endmodule

@@ rtl/line_line_closest_midpoint_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_line_closest_midpoint_3d
// Midpoint of the closest points of two 3D lines and their squared gap.
// ----------------------------------------------------------------------------
//  channel   | handshake           | beat contents
//  ----------+---------------------+-------------------------------------------
//  command   | start / busy        | i_p1_*, i_dir1_*, i_p2_*, i_dir2_*
//  result    | o_valid (strobe)    | o_mid_*, o_gap_squared, o_parallel
//
//  A command beat is taken on any edge with start high; busy stays low since
//  the pipeline never holds. Every stage registers its work, so one beat per
//  cycle flows through. The pipeline has 6 front stages (dot products,
//  denominator, numerators), 100 divider stages (one quotient bit each, set
//  by the 100-bit dividend) and 9 back stages. o_valid is a one-cycle strobe;
//  the receiver cannot stall. Synchronous reset drops all in-flight beats.
// ----------------------------------------------------------------------------
module line_line_closest_midpoint_3d (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_p1_x,
    input  logic signed [31:0] i_p1_y,
    input  logic signed [31:0] i_p1_z,
    input  logic signed [15:0] i_dir1_x,
    input  logic signed [15:0] i_dir1_y,
    input  logic signed [15:0] i_dir1_z,
    input  logic signed [31:0] i_p2_x,
    input  logic signed [31:0] i_p2_y,
    input  logic signed [31:0] i_p2_z,
    input  logic signed [15:0] i_dir2_x,
    input  logic signed [15:0] i_dir2_y,
    input  logic signed [15:0] i_dir2_z,
    output logic               o_valid,
    output logic signed [31:0] o_mid_x,
    output logic signed [31:0] o_mid_y,
    output logic signed [31:0] o_mid_z,
    output logic [47:0]        o_gap_squared,
    output logic               o_parallel
);
    import llcm_pkg::*;

    t_geom  geom;
    logic   front_vld, div_vld;
    t_dbeat front_beat, div_beat;

    // never hold the command side
    assign busy = 1'b0;

    // pack the two lines
    assign geom.q1 = {i_p1_z, i_p1_y, i_p1_x};
    assign geom.v1 = {i_dir1_z, i_dir1_y, i_dir1_x};
    assign geom.q2 = {i_p2_z, i_p2_y, i_p2_x};
    assign geom.v2 = {i_dir2_z, i_dir2_y, i_dir2_x};

    llcm_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (start & ~busy),
        .i_geom  (geom),
        .o_vld   (front_vld),
        .o_beat  (front_beat)
    );

    llcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .i_beat  (front_beat),
        .o_vld   (div_vld),
        .o_beat  (div_beat)
    );

    llcm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_vld         (div_vld),
        .i_beat        (div_beat),
        .o_vld         (o_valid),
        .o_mid_x       (o_mid_x),
        .o_mid_y       (o_mid_y),
        .o_mid_z       (o_mid_z),
        .o_gap_squared (o_gap_squared),
        .o_parallel    (o_parallel)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LATENCY o_valid)
        else $error("accepted beat did not produce a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result without a matching command beat");

    a_parallel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_parallel) |->
            (o_mid_x == 0 && o_mid_y == 0 && o_mid_z == 0 && o_gap_squared == 0))
        else $error("parallel result carries nonzero outputs");

endmodule

@@ test/llcm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// llcm_checker
// Watches the command and result channels of the closest-midpoint block,
// predicts each result from the accepted command beat and compares it.
// ----------------------------------------------------------------------------
module llcm_checker
    import llcm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               busy,
    input  t_geom              i_geom,
    input  logic               i_valid,
    input  logic signed [31:0] i_mid_x,
    input  logic signed [31:0] i_mid_y,
    input  logic signed [31:0] i_mid_z,
    input  logic [47:0]        i_gap_squared,
    input  logic               i_parallel,
    output int                 o_errors,
    output int                 o_pending
);

    typedef logic signed [127:0] t_wide;
    typedef logic [127:0]        t_uwide;

    typedef struct {
        logic signed [31:0] mid [3];
        logic [47:0]        gap;
        logic               parallel;
    } t_midgap;

    t_midgap midgap_q[$];

    // Signed quotient, rounded to nearest with ties away from zero.
    function automatic t_wide div_round(input t_wide num, input t_wide den);
        t_uwide mn, md, q;
        mn = (num < 0) ? -num : num;
        md = (den < 0) ? -den : den;
        q  = (mn + (md >> 1)) / md;
        return ((num < 0) != (den < 0)) ? -t_wide'(q) : t_wide'(q);
    endfunction

    function automatic t_midgap predict_midgap(input t_geom g);
        t_midgap r;
        longint  b, d, e, w;
        t_wide   den, num_s, num_t, s, t, n1, n2, m;
        t_uwide  mag, gsum;
        b = 0; d = 0; e = 0; gsum = '0;
        for (int i = 0; i < 3; i++) begin
            w  = longint'($signed(g.q1[i])) - longint'($signed(g.q2[i]));
            b += longint'($signed(g.v1[i])) * longint'($signed(g.v2[i]));
            d += w * longint'($signed(g.v1[i]));
            e += w * longint'($signed(g.v2[i]));
        end
        den = (t_wide'(1) <<< 60) - t_wide'(b) * t_wide'(b);
        r.parallel = (den == 0);
        r.gap = '0;
        for (int i = 0; i < 3; i++) r.mid[i] = '0;
        if (r.parallel) return r;
        num_s = t_wide'(b) * t_wide'(e) - (t_wide'(d) <<< 30);
        num_t = (t_wide'(e) <<< 30) - t_wide'(b) * t_wide'(d);
        s = div_round(num_s <<< 15, den);
        t = div_round(num_t <<< 15, den);
        for (int i = 0; i < 3; i++) begin
            n1 = (t_wide'($signed(g.q1[i])) <<< 15) + t_wide'($signed(g.v1[i])) * s;
            n2 = (t_wide'($signed(g.q2[i])) <<< 15) + t_wide'($signed(g.v2[i])) * t;
            m  = (n1 + n2 + 32768) >>> 16;
            if (m < -t_wide'(64'sh8000_0000))      r.mid[i] = 32'sh8000_0000;
            else if (m > t_wide'(64'sh7FFF_FFFF))  r.mid[i] = 32'sh7FFF_FFFF;
            else                                   r.mid[i] = m[31:0];
            mag = ((n1 - n2) < 0) ? -(n1 - n2) : (n1 - n2);
            if (mag > (t_uwide'(1) << 55)) mag = t_uwide'(1) << 55;
            gsum += mag * mag;
        end
        gsum = (gsum + (t_uwide'(1) << 45)) >> 46;
        if (gsum > t_uwide'(48'hFFFF_FFFF_FFFF)) gsum = t_uwide'(48'hFFFF_FFFF_FFFF);
        r.gap = gsum[47:0];
        return r;
    endfunction

    assign o_pending = midgap_q.size();

    always_ff @(posedge i_clk) begin
        t_midgap exp_r;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (start && !busy) midgap_q.push_back(predict_midgap(i_geom));
            if (i_valid) begin
                if (midgap_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_r = midgap_q.pop_front();
                    if (exp_r.mid[0] !== i_mid_x || exp_r.mid[1] !== i_mid_y ||
                        exp_r.mid[2] !== i_mid_z || exp_r.gap !== i_gap_squared ||
                        exp_r.parallel !== i_parallel) begin
                        $display("%0t: mismatch exp mid=(%0d,%0d,%0d) gap=%0d par=%b",
                                 $time, exp_r.mid[0], exp_r.mid[1], exp_r.mid[2],
                                 exp_r.gap, exp_r.parallel);
                        $display("%0t:          act mid=(%0d,%0d,%0d) gap=%0d par=%b",
                                 $time, i_mid_x, i_mid_y, i_mid_z,
                                 i_gap_squared, i_parallel);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end

endmodule

@@ test/tb_line_line_closest_midpoint_3d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_line_closest_midpoint_3d
// Drives line pairs into the closest-midpoint pipeline: a directed set of
// extremes and parallel cases, then random beats with random gaps. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_line_line_closest_midpoint_3d;
    import llcm_pkg::*;

    localparam int N_RANDOM = 1100;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_geom              geom;
    logic               o_valid;
    logic signed [31:0] o_mid_x, o_mid_y, o_mid_z;
    logic [47:0]        o_gap_squared;
    logic               o_parallel;
    int                 errors;
    int                 pending;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    line_line_closest_midpoint_3d dut (
        .i_clk, .i_rst_n, .start, .busy,
        .i_p1_x(geom.q1[0]), .i_p1_y(geom.q1[1]), .i_p1_z(geom.q1[2]),
        .i_dir1_x(geom.v1[0]), .i_dir1_y(geom.v1[1]), .i_dir1_z(geom.v1[2]),
        .i_p2_x(geom.q2[0]), .i_p2_y(geom.q2[1]), .i_p2_z(geom.q2[2]),
        .i_dir2_x(geom.v2[0]), .i_dir2_y(geom.v2[1]), .i_dir2_z(geom.v2[2]),
        .o_valid, .o_mid_x, .o_mid_y, .o_mid_z, .o_gap_squared, .o_parallel
    );

    llcm_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_geom(geom),
        .i_valid(o_valid), .i_mid_x(o_mid_x), .i_mid_y(o_mid_y),
        .i_mid_z(o_mid_z), .i_gap_squared(o_gap_squared),
        .i_parallel(o_parallel), .o_errors(errors), .o_pending(pending)
    );

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one beat, hold it until taken, then leave start low for the gap, if any.
    task automatic send_beat(input t_geom g, input int gap);
        geom  <= g;
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random unit direction in Q1.15.
    function automatic t_dir [2:0] unit_dir();
        t_dir [2:0] v;
        real        c[3];
        real        len;
        do begin
            for (int i = 0; i < 3; i++) c[i] = real'($urandom_range(0, 65534)) - 32767.0;
            len = $sqrt(c[0] * c[0] + c[1] * c[1] + c[2] * c[2]);
        end while (len < 100.0);
        for (int i = 0; i < 3; i++) v[i] = t_dir'($rtoi(c[i] / len * 32767.0));
        return v;
    endfunction

    // Positions: mostly a modest box, sometimes anything.
    function automatic t_pos rand_pos(input bit full);
        if (full) return t_pos'($urandom);
        return t_pos'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endfunction

    function automatic t_geom rand_geom();
        t_geom g;
        int    kind;
        bit    full;
        kind = $urandom_range(0, 99);
        full = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < 3; i++) begin
            g.q1[i] = rand_pos(full);
            g.q2[i] = rand_pos(full);
        end
        g.v1 = unit_dir();
        g.v2 = unit_dir();
        if (kind < 10) begin
            // nearly parallel: nudge a copy of the first direction
            for (int i = 0; i < 3; i++)
                g.v2[i] = g.v1[i] + t_dir'($signed($urandom_range(0, 6)) - 3);
        end else if (kind < 15) begin
            // exactly parallel along an axis, same sense
            g.v1 = '0; g.v2 = '0;
            g.v1[kind % 3] = 16'sh8000;
            g.v2[kind % 3] = 16'sh8000;
        end else if (kind < 25) begin
            // raw bits, directions of any length
            for (int i = 0; i < 3; i++) begin
                g.v1[i] = t_dir'($urandom);
                g.v2[i] = t_dir'($urandom);
            end
        end
        return g;
    endfunction

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_geom g;
        i_rst_n = 1'b0;
        start   = 1'b0;
        geom    = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: all zero, axis lines, extremes, both parallel senses.
        g = '0;
        send_beat(g, 0);
        g.v1[0] = 16'sh7FFF; g.v2[1] = 16'sh7FFF; g.q2[2] = 32'sh0001_0000;
        send_beat(g, 1);
        g.v1 = '0; g.v2 = '0;
        g.v1[0] = 16'sh8000; g.v2[0] = 16'sh8000;
        send_beat(g, 0);
        g.v1 = '0; g.v2 = '0;
        g.v1[0] = 16'sh8000; g.v1[1] = 16'sh8000;
        g.v2[0] = 16'sh4000; g.v2[1] = 16'sh4000;
        send_beat(g, 2);
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                g.q1[i] = (k[0]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                g.q2[i] = (k[1]) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                g.v1[i] = (k[0]) ? 16'sh7FFF : 16'sh8000;
                g.v2[i] = (k[1]) ? 16'sh8000 : 16'sh7FFF;
            end
            g.v2[k % 3] = 16'sh0001;
            send_beat(g, k % 2);
        end
        for (int k = 0; k < 4; k++) begin
            for (int i = 0; i < 3; i++) begin
                g.q1[i] = 32'sh7FFF_FFFF;
                g.q2[i] = 32'sh8000_0000;
            end
            g.v1 = unit_dir();
            g.v2 = g.v1;
            g.v2[k % 3] = g.v2[k % 3] + 16'sh0001;
            send_beat(g, 0);
        end
        g = '1;
        send_beat(g, 3);

        for (int n = 0; n < N_RANDOM; n++) send_beat(rand_geom(), pick_gap());
        start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ line_line_closest_midpoint_3d.f @@
rtl/llcm_pkg.sv
rtl/llcm_front.sv
rtl/llcm_div.sv
rtl/llcm_back.sv
rtl/line_line_closest_midpoint_3d.sv
test/llcm_checker.sv
test/tb_line_line_closest_midpoint_3d.sv
